/* src/utf8_validating_decoder_assert.svh */
// Assertion macros for the decoder checker.
`ifndef UTF8_VALIDATING_DECODER_ASSERT_SVH
`define UTF8_VALIDATING_DECODER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UVD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8 decoder check failed");

// Consequent must hold in the cycle after the antecedent.
`define UVD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 decoder check failed");

`endif

/* src/utf8vd_pkg.sv */
// Types and constants for the UTF-8 validating decoder.
`default_nettype none

package utf8vd_pkg;

  localparam int unsigned CP_W  = 21;
  localparam int unsigned LEN_W = 3;

  localparam logic [7:0] LEAD_MASK    = 8'hC0;
  localparam logic [7:0] CONT_TAG     = 8'h80;
  localparam logic [7:0] CONT_PAYLOAD = 8'h3F;

  localparam logic [CP_W-1:0] MIN_2B     = 21'h000080;
  localparam logic [CP_W-1:0] MIN_3B     = 21'h000800;
  localparam logic [CP_W-1:0] MIN_4B     = 21'h010000;
  localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;
  localparam logic [CP_W-1:0] NONCHAR_LO = 21'h00FFFE;
  localparam logic [CP_W-1:0] NONCHAR_HI = 21'h00FFFF;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;

  typedef struct packed {
    logic             valid;
    logic [CP_W-1:0]  code_point;
    logic             error;
    logic [LEN_W-1:0] seq_length;
  } res_t;

endpackage

`default_nettype wire

/* src/utf8vd_in_stage.sv */
// Input register: holds one byte until the decode step takes it.
`default_nettype none

module utf8vd_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  input  wire logic       take,
  output logic            hold_valid,
  output logic [7:0]      hold_byte
);
  import utf8vd_pkg::*;

  logic       valid_r;
  logic [7:0] byte_r;

  assign in_stall   = valid_r && !take;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_byte;
    end
  end

endmodule

`default_nettype wire

/* src/utf8vd_step.sv */
// Decode step: sequence state and the per-byte update and checks.
`default_nettype none

module utf8vd_step (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic [7:0] data,
  input  wire logic       fire,
  output utf8vd_pkg::res_t res
);
  import utf8vd_pkg::*;

  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [1:0]      rem_r, rem_nxt;
  logic [1:0]      tot_r, tot_nxt;

  logic            is_cont;
  logic [CP_W-1:0] shifted;
  logic [CP_W-1:0] minimum;
  logic            bad;

  assign is_cont = (data & LEAD_MASK) == CONT_TAG;
  assign shifted = {acc_r[CP_W-7:0], data[5:0] & CONT_PAYLOAD[5:0]};

  always_comb begin
    case (tot_r)
      2'd1:    minimum = MIN_2B;
      2'd2:    minimum = MIN_3B;
      default: minimum = MIN_4B;
    endcase
    bad = (shifted < minimum)
       || (shifted >= SURR_LO && shifted <= SURR_HI)
       || (shifted == NONCHAR_LO) || (shifted == NONCHAR_HI)
       || (shifted > CP_MAX);
  end

  always_comb begin
    res     = '0;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    tot_nxt = tot_r;
    if (rem_r == 2'd0) begin
      if (is_cont) begin
        res.valid      = 1'b1;
        res.error      = 1'b1;
        res.seq_length = 3'd1;
      end else if (!data[7]) begin
        res.valid      = 1'b1;
        res.code_point = {13'd0, data};
        res.seq_length = 3'd1;
      end else if (data inside {[8'hF8:8'hFF]}) begin
        res.valid      = 1'b1;
        res.error      = 1'b1;
        res.seq_length = 3'd1;
      end else if (data inside {[8'hC0:8'hDF]}) begin
        tot_nxt = 2'd1;
        rem_nxt = 2'd1;
        acc_nxt = {16'd0, data[4:0]};
      end else if (data inside {[8'hE0:8'hEF]}) begin
        tot_nxt = 2'd2;
        rem_nxt = 2'd2;
        acc_nxt = {17'd0, data[3:0]};
      end else begin
        tot_nxt = 2'd3;
        rem_nxt = 2'd3;
        acc_nxt = {18'd0, data[2:0]};
      end
    end else if (!is_cont) begin
      // broken sequence: this byte is counted and consumed
      res.valid      = 1'b1;
      res.error      = 1'b1;
      res.seq_length = {1'b0, tot_r} - {1'b0, rem_r} + 3'd2;
      acc_nxt        = '0;
      rem_nxt        = 2'd0;
      tot_nxt        = 2'd0;
    end else begin
      acc_nxt = shifted;
      rem_nxt = rem_r - 2'd1;
      if (rem_r == 2'd1) begin
        res.valid      = 1'b1;
        res.error      = bad;
        res.code_point = bad ? '0 : shifted;
        res.seq_length = {1'b0, tot_r} + 3'd1;
        acc_nxt        = '0;
        tot_nxt        = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= 2'd0;
      tot_r <= 2'd0;
    end else if (fire) begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      tot_r <= tot_nxt;
    end
  end

endmodule

`default_nettype wire

/* src/utf8vd_out_stage.sv */
// Result register on the output channel.
`default_nettype none

module utf8vd_out_stage (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire utf8vd_pkg::res_t           res,
  input  wire logic                       load,
  output logic                            free,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [utf8vd_pkg::CP_W-1:0]     out_code_point,
  output logic                            out_error,
  output logic [utf8vd_pkg::LEN_W-1:0]    out_seq_length
);
  import utf8vd_pkg::*;

  logic             valid_r;
  logic [CP_W-1:0]  cp_r;
  logic             err_r;
  logic [LEN_W-1:0] len_r;

  assign free           = !valid_r || !out_stall;
  assign out_valid      = valid_r;
  assign out_code_point = cp_r;
  assign out_error      = err_r;
  assign out_seq_length = len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r  <= res.code_point;
      err_r <= res.error;
      len_r <= res.seq_length;
    end
  end

endmodule

`default_nettype wire

/* src/utf8_validating_decoder.sv */
// Top level of the UTF-8 validating decoder.
// A result is registered in the output stage when the last byte of its sequence is decoded.
// Throughput: one byte per cycle while no result waits on a stalled output; the sequence state updates per byte.
// Lead bytes that open a sequence and non-final continuation bytes give no result and never wait on the output.
// Reset (rst_n low, synchronous) empties both registers and returns the decoder to idle.
`default_nettype none

module utf8_validating_decoder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [7:0]                 in_byte,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [utf8vd_pkg::CP_W-1:0]     out_code_point,
  output logic                            out_error,
  output logic [utf8vd_pkg::LEN_W-1:0]    out_seq_length
);
  import utf8vd_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       fire;
  logic       free;
  res_t       res;

  assign fire = hold_valid && (!res.valid || free);

  utf8vd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .take       (fire),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte)
  );

  utf8vd_step u_step (
    .clk   (clk),
    .rst_n (rst_n),
    .data  (hold_byte),
    .fire  (fire),
    .res   (res)
  );

  utf8vd_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .res            (res),
    .load           (fire && res.valid),
    .free           (free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_code_point (out_code_point),
    .out_error      (out_error),
    .out_seq_length (out_seq_length)
  );

endmodule

`default_nettype wire

/* src/utf8vd_checker.sv */
// Port-level checks for the UTF-8 validating decoder, bound to the top level.
`default_nettype none

`include "utf8_validating_decoder_assert.svh"

module utf8vd_checker (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [utf8vd_pkg::CP_W-1:0]  out_code_point,
  input wire logic                    out_error,
  input wire logic [utf8vd_pkg::LEN_W-1:0] out_seq_length
);
  import utf8vd_pkg::*;

  `UVD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_code_point) && $stable(out_error) && $stable(out_seq_length))

  `UVD_ASSERT_NOW(a_err_zero_cp, out_valid && out_error, out_code_point == '0)

  `UVD_ASSERT_NOW(a_good_range, out_valid && !out_error, out_code_point <= CP_MAX && out_seq_length >= 3'd1 && out_seq_length <= 3'd4)

  `UVD_ASSERT_NOW(a_ascii_len, out_valid && !out_error && out_seq_length == 3'd1, out_code_point < MIN_2B)

endmodule

bind utf8_validating_decoder utf8vd_checker u_chk (.*);

`default_nettype wire
